FILE: rtl/spf_pkg.sv
// spf_pkg: types, constants and helpers shared by the stream pattern finder
// holds the beat structs, the register index codes and the case fold function
// no dependencies
package spf_pkg;

	// default window depth, longest pattern that can be searched
	localparam int MAX_PATTERN_DEF = 16;

	// pattern bytes held by the two pattern registers
	localparam int PAT_REG_BYTES = 16;

	// field and register widths
	localparam int OFFSET_W  = 48;
	localparam int CFG_DATA_W = 64;
	localparam int CFG_IDX_W  = 3;
	localparam int LEN_REG_W  = 5;

	localparam logic [OFFSET_W-1:0] OFFSET_MAX = {OFFSET_W{1'b1}};

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PATTERN_LOW  = 3'd0,
		CFG_PATTERN_HIGH = 3'd1,
		CFG_PATTERN_LEN  = 3'd2,
		CFG_FOLD_CASE    = 3'd3,
		CFG_START_OFFSET = 3'd4
	} cfg_reg_t;

	// input beat
	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_beat_t;

	// result beat
	typedef struct packed {
		logic                found;
		logic [OFFSET_W-1:0] match_offset;
	} out_beat_t;

	// ascii upper case letters to lower case when folding is on
	function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic en);
		logic [7:0] r;
		r = b;
		if (en && b >= 8'h41 && b <= 8'h5A) begin
			r = b + 8'h20;
		end
		return r;
	endfunction

endpackage

FILE: rtl/stream_pattern_finder_top.sv
// stream_pattern_finder_top: first occurrence search of a short byte pattern
// in a byte stream, window register, parallel comparators and result register
// depends on spf_pkg
//
// Takes one stream byte per cycle and reports the first place where the
// configured pattern (1 to MAX_PATTERN bytes, exact or ASCII case-folded)
// occurs, as start_offset plus the index of its first byte, or a not-found
// beat when the stream's last byte passes without a match. The accepted byte
// first shifts into the window register, then all window positions are
// compared at once against the pattern and the result goes into the output
// register. A new byte is taken every cycle; only a result held in the output
// register under stall holds up the input. The user must see that configuration
// is written while no stream is in flight; the block itself does not enforce it.
module stream_pattern_finder_top #(
	parameter int MAX_PATTERN = spf_pkg::MAX_PATTERN_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration write port
	input  logic                                 cfg_write,
	input  logic [spf_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [spf_pkg::CFG_DATA_W-1:0]       cfg_data,
	// stream bytes in
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  spf_pkg::in_beat_t                    in_data,
	// results out
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output spf_pkg::out_beat_t                   out_data
);

	localparam int LW = $clog2(MAX_PATTERN + 1);
	localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int OW = spf_pkg::OFFSET_W;

	// configuration registers
	logic [2*spf_pkg::CFG_DATA_W-1:0]  pattern_q;
	logic [spf_pkg::LEN_REG_W-1:0]     pattern_len_q;
	logic                              fold_case_q;
	logic [OW-1:0]                     start_offset_q;

	// stream state, also holding the byte in the compare stage
	logic [7:0]    window_q [MAX_PATTERN];
	logic [OW-1:0] count_q;
	logic          restart_q;
	logic          match_done_q;
	logic          valid_s1;
	logic          last_s1;

	// output register
	logic                  out_valid_q;
	spf_pkg::out_beat_t    out_q;

	logic                  in_accept;
	logic                  out_free;
	logic                  advance;
	logic [LW-1:0]         len_eff;
	logic [OW-1:0]         count_base;
	logic [OW-1:0]         count_next;
	logic [MAX_PATTERN-1:0] pos_ok;
	logic                  hit;
	logic                  produce;
	logic [OW-1:0]         match_pos;
	logic [OW:0]           offset_sum;
	logic [OW-1:0]         offset_sat;

	// handshake
	assign out_free  = !out_valid_q || !out_stall;
	assign advance   = valid_s1 && out_free;
	assign in_stall  = valid_s1 && !out_free;
	assign in_accept = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q      <= '0;
			pattern_len_q  <= spf_pkg::LEN_REG_W'(1);
			fold_case_q    <= 1'b0;
			start_offset_q <= '0;
		end else if (cfg_write) begin
			unique case (spf_pkg::cfg_reg_t'(cfg_index))
				spf_pkg::CFG_PATTERN_LOW:
					pattern_q[spf_pkg::CFG_DATA_W-1:0] <= cfg_data;
				spf_pkg::CFG_PATTERN_HIGH:
					pattern_q[2*spf_pkg::CFG_DATA_W-1:spf_pkg::CFG_DATA_W] <= cfg_data;
				spf_pkg::CFG_PATTERN_LEN:
					pattern_len_q <= cfg_data[spf_pkg::LEN_REG_W-1:0];
				spf_pkg::CFG_FOLD_CASE:
					fold_case_q <= cfg_data[0];
				spf_pkg::CFG_START_OFFSET:
					start_offset_q <= cfg_data[OW-1:0];
				default: begin
				end
			endcase
		end
	end

	// position count, restarts after a last byte and saturates
	always_comb begin
		count_base = restart_q ? '0 : count_q;
		count_next = (count_base == spf_pkg::OFFSET_MAX) ? count_base
			: count_base + OW'(1);
	end

	// window shift and stage control on an accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_PATTERN; i++) begin
				window_q[i] <= '0;
			end
			count_q   <= '0;
			restart_q <= 1'b0;
			valid_s1  <= 1'b0;
			last_s1   <= 1'b0;
		end else begin
			if (in_accept) begin
				window_q[0] <= in_data.data_byte;
				for (int i = 1; i < MAX_PATTERN; i++) begin
					window_q[i] <= restart_q ? 8'h00 : window_q[i-1];
				end
				count_q   <= count_next;
				restart_q <= in_data.last_byte;
				last_s1   <= in_data.last_byte;
				valid_s1  <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// effective pattern length, zero acts as one, clipped to the window
	always_comb begin
		if (pattern_len_q == '0) begin
			len_eff = LW'(1);
		end else if (32'(pattern_len_q) > MAX_PATTERN) begin
			len_eff = LW'(MAX_PATTERN);
		end else begin
			len_eff = LW'(pattern_len_q);
		end
	end

	// one comparator per pattern byte, pattern byte k against window byte len-1-k
	for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cmp
		logic [7:0]    pat_b;
		logic [LW-1:0] back_pos;
		logic [IW-1:0] widx;
		if (k < spf_pkg::PAT_REG_BYTES) begin : g_pat
			assign pat_b = pattern_q[8*k +: 8];
		end else begin : g_zero
			assign pat_b = 8'h00;
		end
		assign back_pos = len_eff - LW'(k + 1);
		assign widx = back_pos[IW-1:0];
		assign pos_ok[k] = (LW'(k) >= len_eff)
			|| (spf_pkg::fold_byte(window_q[widx], fold_case_q)
				== spf_pkg::fold_byte(pat_b, fold_case_q));
	end

	// match decision and offset
	always_comb begin
		hit        = !match_done_q && (count_q >= OW'(len_eff)) && (&pos_ok);
		produce    = hit || (last_s1 && !match_done_q);
		match_pos  = count_q - OW'(len_eff);
		offset_sum = {1'b0, start_offset_q} + {1'b0, match_pos};
		offset_sat = offset_sum[OW] ? spf_pkg::OFFSET_MAX : offset_sum[OW-1:0];
	end

	// match flag, cleared when the stream ends
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_done_q <= 1'b0;
		end else if (advance) begin
			if (last_s1) begin
				match_done_q <= 1'b0;
			end else if (hit) begin
				match_done_q <= 1'b1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && produce) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && produce) begin
			out_q.found        <= hit;
			out_q.match_offset <= hit ? offset_sat : '0;
		end
	end

	// a found beat never lies below the start offset
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.found |-> out_q.match_offset >= start_offset_q)
		else $error("match offset below start offset");

	// a not-found beat carries a zero offset
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_q.found |-> out_q.match_offset == '0)
		else $error("not-found beat with nonzero offset");

	// no second match is reported within one stream
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && hit && !last_s1 |=> match_done_q)
		else $error("match flag not set after a match");

	// the position count only grows within a stream
	assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && !restart_q |=> count_q >= $past(count_q))
		else $error("position count went backward");

endmodule
